/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLIES(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ola_pkg.sv */
// shared constants, codes and types of the overlap alignment score engine
package ola_pkg;

	// read capacity and derived widths
	localparam int MaxReadLen = 256;
	localparam int LenW       = $clog2(MaxReadLen + 1);
	localparam int AddrW      = (MaxReadLen > 1) ? $clog2(MaxReadLen) : 1;
	localparam int RowDepth   = MaxReadLen + 1;

	// fixed field widths
	localparam int SymW     = 8;
	localparam int ReqW     = 2;
	localparam int ScoreW   = 14;
	localparam int ColW     = 9;
	localparam int BonusW   = 5;
	localparam int GapW     = 4;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 5;
	// score, column and overflow flag fill exactly three bytes
	localparam int OutDataW = ScoreW + ColW + 1;

	// saturation limits of a stored score
	localparam logic signed [ScoreW-1:0] ScoreMax = {1'b0, {(ScoreW - 1){1'b1}}};
	localparam logic signed [ScoreW-1:0] ScoreMin = {1'b1, {(ScoreW - 1){1'b0}}};

	// register reset values
	localparam logic signed [BonusW-1:0] MatchReset    = 5'sd2;
	localparam logic signed [BonusW-1:0] MismatchReset = -5'sd1;
	localparam logic [GapW-1:0]          GapReset      = 4'd1;

	// request codes carried in the item's user field
	typedef enum logic [ReqW-1:0] {
		REQ_LOAD_A  = 2'd0,
		REQ_LOAD_B  = 2'd1,
		REQ_COMPUTE = 2'd2
	} req_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_MATCH    = 2'd0,
		CFG_MISMATCH = 2'd1,
		CFG_GAP      = 2'd2
	} cfg_idx_t;

	// position of a cell in the table
	typedef struct packed {
		logic row0;
		logic col0;
	} cell_ctl_t;

endpackage

/* hw/rtl/ola_ram.sv */
// generic single-write single-read ram with registered read data
module ola_ram #(
	parameter int Width = 8,
	parameter int Depth = 256,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/ola_cell.sv */
// score of one table cell from its three neighbours, saturated to the score range
module ola_cell (
	input  ola_pkg::cell_ctl_t               ctl,
	input  logic signed [ola_pkg::ScoreW-1:0] up,
	input  logic signed [ola_pkg::ScoreW-1:0] left,
	input  logic signed [ola_pkg::ScoreW-1:0] diag,
	input  logic [ola_pkg::SymW-1:0]          sym_a,
	input  logic [ola_pkg::SymW-1:0]          sym_b,
	input  logic signed [ola_pkg::BonusW-1:0] match_bonus,
	input  logic signed [ola_pkg::BonusW-1:0] mismatch_score,
	input  logic [ola_pkg::GapW-1:0]          gap_cost,
	output logic signed [ola_pkg::ScoreW-1:0] score
);

	import ola_pkg::*;

	localparam int WW = ScoreW + 2;

	logic signed [WW-1:0] gap_w;
	logic signed [WW-1:0] step_w;
	logic signed [WW-1:0] up_g;
	logic signed [WW-1:0] left_g;
	logic signed [WW-1:0] diag_s;
	logic signed [WW-1:0] best_ul;
	logic signed [WW-1:0] raw;

	// candidate scores in a widened range
	always_comb begin
		gap_w  = WW'(signed'({1'b0, gap_cost}));
		step_w = (sym_a == sym_b) ? WW'(match_bonus) : WW'(mismatch_score);
		up_g   = WW'(up) - gap_w;
		left_g = WW'(left) - gap_w;
		diag_s = WW'(diag) + step_w;
		best_ul = (up_g > left_g) ? up_g : left_g;
	end

	// pick by position: origin, first row, first column, inner cell
	always_comb begin
		priority if (ctl.row0 && ctl.col0) begin
			raw = '0;
		end else if (ctl.row0) begin
			raw = left_g;
		end else if (ctl.col0) begin
			raw = up_g;
		end else begin
			raw = (diag_s > best_ul) ? diag_s : best_ul;
		end
	end

	// saturate as stored
	always_comb begin
		priority if (raw > WW'(ScoreMax)) begin
			score = ScoreMax;
		end else if (raw < WW'(ScoreMin)) begin
			score = ScoreMin;
		end else begin
			score = ScoreW'(raw);
		end
	end

endmodule

/* hw/rtl/overlap_alignment_score.sv */
// top level of the overlap alignment score engine
//
//  channel  | direction | handshake           | payload
//  s        | in        | s_tvalid/s_tready   | s_tuser req_type, s_tdata symbol
//  m        | out       | m_tvalid/m_tready   | m_tdata best_score, best_column, overflow
//  cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a compute item walks the table of (L1 + 1) rows by (L2 + 1) columns row by row,
// L1 and L2 being the read lengths, through the single read port of the score row ram
// that reads each table row once, plus one turn-around state per row.
// reset clears lengths, flag, control and configuration registers; the rams hold no reset state.
// loads are taken while a result waits on m; a finished compute holds until m is free.
module overlap_alignment_score (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ola_pkg::SymW-1:0]      s_tdata,   // [7:0] symbol
	input  logic [ola_pkg::ReqW-1:0]      s_tuser,   // [1:0] req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ola_pkg::OutDataW-1:0]  m_tdata,   // [13:0] best_score, [22:14] best_column,
	                                                 // [23] overflow
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ola_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ola_pkg::CfgDataW-1:0]  cfg_data
);

	import ola_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_ROWEND = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t state_q;

	logic signed [BonusW-1:0] match_q;
	logic signed [BonusW-1:0] mismatch_q;
	logic [GapW-1:0]          gap_q;

	logic [LenW-1:0] len_a_q;
	logic [LenW-1:0] len_b_q;
	logic            dropped_q;
	logic [LenW-1:0] row_q;
	logic [LenW-1:0] col_q;
	logic [LenW-1:0] col_m1;

	logic            vld_s1;
	logic [LenW-1:0] col_s1;
	cell_ctl_t       ctl_s1;
	logic            last_s1;

	logic signed [ScoreW-1:0] left_q;
	logic signed [ScoreW-1:0] diag_q;
	logic signed [ScoreW-1:0] best_q;
	logic [LenW-1:0]          best_col_q;
	logic signed [ScoreW-1:0] cell_score;

	logic              m_tvalid_q;
	logic [ScoreW-1:0] m_score_q;
	logic [ColW-1:0]   m_col_q;
	logic              m_ovf_q;

	logic in_acc;
	logic scan;
	logic fr_re;
	logic out_free;
	req_t req;

	logic                     fr_we;
	logic                     sr_we;
	logic [SymW-1:0]          fr_rdata;
	logic [SymW-1:0]          sr_rdata;
	logic signed [ScoreW-1:0] row_rdata;
	logic [ScoreW-1:0]        row_rdata_u;

	// handshake and control decode
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign req       = req_t'(s_tuser);
	assign scan      = (state_q == ST_SCAN);
	assign fr_re     = (state_q == ST_ROWEND) && (row_q != len_a_q);
	assign out_free  = !m_tvalid_q || m_tready;
	assign fr_we     = in_acc && (req == REQ_LOAD_A) && (len_a_q < LenW'(MaxReadLen));
	assign sr_we     = in_acc && (req == REQ_LOAD_B) && (len_b_q < LenW'(MaxReadLen));
	assign col_m1    = col_q - LenW'(1);
	assign row_rdata = signed'(row_rdata_u);

	// symbol stores of both reads
	ola_ram #(.Width(SymW), .Depth(MaxReadLen)) u_first_read (
		.clk   (clk),
		.we    (fr_we),
		.waddr (len_a_q[AddrW-1:0]),
		.wdata (s_tdata),
		.re    (fr_re),
		.raddr (row_q[AddrW-1:0]),
		.rdata (fr_rdata)
	);

	ola_ram #(.Width(SymW), .Depth(MaxReadLen)) u_second_read (
		.clk   (clk),
		.we    (sr_we),
		.waddr (len_b_q[AddrW-1:0]),
		.wdata (s_tdata),
		.re    (scan),
		.raddr (col_m1[AddrW-1:0]),
		.rdata (sr_rdata)
	);

	// working row of the table, read ahead of the write of the same column
	ola_ram #(.Width(ScoreW), .Depth(RowDepth)) u_score_row (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (col_s1),
		.wdata (cell_score),
		.re    (scan),
		.raddr (col_q),
		.rdata (row_rdata_u)
	);

	// cell update
	ola_cell u_cell (
		.ctl            (ctl_s1),
		.up             (row_rdata),
		.left           (left_q),
		.diag           (diag_q),
		.sym_a          (fr_rdata),
		.sym_b          (sr_rdata),
		.match_bonus    (match_q),
		.mismatch_score (mismatch_q),
		.gap_cost       (gap_q),
		.score          (cell_score)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= MatchReset;
			mismatch_q <= MismatchReset;
			gap_q      <= GapReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MATCH: begin
					match_q <= signed'(cfg_data);
				end
				CFG_MISMATCH: begin
					mismatch_q <= signed'(cfg_data);
				end
				CFG_GAP: begin
					gap_q <= cfg_data[GapW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer: loads, row walk and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_a_q   <= '0;
			len_b_q   <= '0;
			dropped_q <= 1'b0;
			row_q     <= '0;
			col_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (req)
							REQ_LOAD_A: begin
								if (fr_we) begin
									len_a_q <= len_a_q + LenW'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							REQ_LOAD_B: begin
								if (sr_we) begin
									len_b_q <= len_b_q + LenW'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							REQ_COMPUTE: begin
								row_q   <= '0;
								col_q   <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (col_q == len_b_q) begin
						col_q   <= '0;
						state_q <= ST_ROWEND;
					end else begin
						col_q <= col_q + LenW'(1);
					end
				end
				ST_ROWEND: begin
					if (row_q == len_a_q) begin
						state_q <= ST_DONE;
					end else begin
						row_q   <= row_q + LenW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						len_a_q   <= '0;
						len_b_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// issue stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= scan;
		end
	end

	// issue stage payload
	always_ff @(posedge clk) begin
		col_s1      <= col_q;
		ctl_s1.row0 <= (row_q == '0);
		ctl_s1.col0 <= (col_q == '0);
		last_s1     <= (row_q == len_a_q);
	end

	// neighbours for the next cell and running best of the last row
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			left_q <= cell_score;
			diag_q <= row_rdata;
			if (last_s1 && (ctl_s1.col0 || (cell_score > best_q))) begin
				best_q     <= cell_score;
				best_col_q <= col_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_score_q <= best_q;
			m_col_q   <= ColW'(best_col_q);
			m_ovf_q   <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_ovf_q, m_col_q, m_score_q};

endmodule

/* hw/rtl/ola_checker.sv */
// port-level checks of the overlap alignment score engine, bound to the top level
`include "assert_macros.svh"

module ola_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [ola_pkg::ReqW-1:0]      s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ola_pkg::OutDataW-1:0]  m_tdata
);

	import ola_pkg::*;

	logic            compute_acc;
	logic            out_stall;
	logic [ColW-1:0] col_field;
	logic            col_ok;

	assign compute_acc = s_tvalid && s_tready && (s_tuser == REQ_COMPUTE);
	assign out_stall   = m_tvalid && !m_tready;
	assign col_field   = m_tdata[ScoreW +: ColW];
	assign col_ok      = (col_field <= ColW'(MaxReadLen));

	// a stalled result keeps its place and value
	`CHK_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// a compute item keeps the block busy for at least the next cycle
	`CHK_NEXT(a_busy_after_compute, clk, arst_n, compute_acc, !s_tready, "input taken right after a compute item")

	// a new result only appears at the end of a compute, when input is held off
	`CHK_IMPLIES(a_result_from_compute, clk, arst_n, $rose(m_tvalid), $past(!s_tready), "result appeared outside a compute")

	// reported column never lies beyond the longest row
	`CHK_IMPLIES(a_col_range, clk, arst_n, m_tvalid, col_ok, "best column beyond read capacity")

endmodule

bind overlap_alignment_score ola_checker u_ola_checker (.*);
